@@ rtl/snfcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package snfcs_pkg;

    // Input word function codes.
    localparam logic [1:0] FUNC_REQUEST = 2'd0;
    localparam logic [1:0] FUNC_HOST_DATA = 2'd1;
    localparam logic [1:0] FUNC_SPI_REPLY = 2'd2;
    localparam logic [1:0] FUNC_TICK = 2'd3;

    // Request kinds.
    localparam logic [2:0] OP_READ_ID = 3'd0;
    localparam logic [2:0] OP_READ = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_SECTOR_ERASE = 3'd3;
    localparam logic [2:0] OP_BLOCK_ERASE = 3'd4;
    localparam logic [2:0] OP_CHIP_ERASE = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_SPI = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_HOST = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // Completion codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_WEL_NOT_SET = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PROGRAM_TO = 2'd0;
    localparam logic [1:0] REG_SECTOR_TO = 2'd1;
    localparam logic [1:0] REG_BLOCK_TO = 2'd2;
    localparam logic [1:0] REG_CHIP_TO = 2'd3;

    // Flash opcodes.
    localparam logic [7:0] OPC_READ_ID = 8'h9F;
    localparam logic [7:0] OPC_READ = 8'h03;
    localparam logic [7:0] OPC_WREN = 8'h06;
    localparam logic [7:0] OPC_RDSR = 8'h05;
    localparam logic [7:0] OPC_PROGRAM = 8'h02;
    localparam logic [7:0] OPC_SECTOR = 8'h20;
    localparam logic [7:0] OPC_BLOCK = 8'hD8;
    localparam logic [7:0] OPC_CHIP = 8'hC7;
    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    localparam int TIMEOUT_W = 20;
    localparam int LEN_W = 25;
    localparam int MAX_RESULTS = 4;

    typedef enum logic [12:0] {
        PH_IDLE      = 13'b0000000000001,
        PH_ID_CMD    = 13'b0000000000010,
        PH_ID_BYTE   = 13'b0000000000100,
        PH_RD_DATA   = 13'b0000000001000,
        PH_WREN      = 13'b0000000010000,
        PH_WEL_CMD   = 13'b0000000100000,
        PH_WEL_READ  = 13'b0000001000000,
        PH_OPC       = 13'b0000010000000,
        PH_ADDR      = 13'b0000100000000,
        PH_DATA_WAIT = 13'b0001000000000,
        PH_DATA_SENT = 13'b0010000000000,
        PH_POLL_CMD  = 13'b0100000000000,
        PH_POLL_READ = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] spi_byte;
        logic [7:0] host_byte;
        logic [1:0] status;
    } result_t;

    // A bundle of up to four results produced by one input word.
    typedef struct packed {
        logic [2:0] count;
        result_t [MAX_RESULTS-1:0] res;
    } bundle_t;

    function automatic logic [7:0] opcode_of(input logic [2:0] op);
        logic [7:0] r;
        case (op)
            OP_READ: r = OPC_READ;
            OP_WRITE: r = OPC_PROGRAM;
            OP_SECTOR_ERASE: r = OPC_SECTOR;
            OP_BLOCK_ERASE: r = OPC_BLOCK;
            default: r = OPC_CHIP;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/snfcs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface snfcs_in_if;
    logic valid;
    logic ready;
    logic [1:0] func;
    logic [2:0] op;
    logic [23:0] address;
    logic [24:0] length;
    logic [7:0] data;
    modport source (output valid, func, op, address, length, data, input ready);
    modport sink (input valid, func, op, address, length, data, output ready);
endinterface

interface snfcs_out_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic [7:0] host_byte;
    logic [1:0] status;
    logic last;
    modport source (output valid, kind, spi_byte, host_byte, status, last, input ready);
    modport sink (input valid, kind, spi_byte, host_byte, status, last, output ready);
endinterface

interface snfcs_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [19:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/snfcs_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module snfcs_core
    import snfcs_pkg::*;
#(
    parameter int PAGE_BYTES = 256,
    parameter int ADDRESS_BITS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic [1:0] func,
    input  wire logic [2:0] op,
    input  wire logic [23:0] address,
    input  wire logic [24:0] length,
    input  wire logic [7:0] data,
    input  wire logic [TIMEOUT_W-1:0] limit_program,
    input  wire logic [TIMEOUT_W-1:0] limit_sector,
    input  wire logic [TIMEOUT_W-1:0] limit_block,
    input  wire logic [TIMEOUT_W-1:0] limit_chip,
    output bundle_t bundle
);
    localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int PLEFT_W = PAGE_W + 1;

    phase_t phase_reg, phase_next;
    logic [2:0] op_reg, op_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [PLEFT_W-1:0] pleft_reg, pleft_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [2:0] hcount_reg, hcount_next;

    logic [TIMEOUT_W-1:0] limit;
    logic [PLEFT_W-1:0] room;
    logic [7:0] addr_sel;
    logic [2:0] hsel;

    // Timeout register for the operation in progress.
    always_comb
    begin
        case (op_reg)
            OP_WRITE: limit = limit_program;
            OP_SECTOR_ERASE: limit = limit_sector;
            OP_BLOCK_ERASE: limit = limit_block;
            default: limit = limit_chip;
        endcase
    end

    // Room left in the current page.
    assign room = PLEFT_W'(PAGE_BYTES) - {1'b0, addr_reg[PAGE_W-1:0]};

    // Address byte k, most significant first.
    always_comb
    begin
        logic [31:0] wide;
        wide = 32'(addr_reg);
        addr_sel = 8'h00;
        for (int k = 0; k < ADDR_BYTES; k++)
        begin
            if (hsel == 3'(k))
            begin
                addr_sel = wide[(ADDR_BYTES-1-k)*8 +: 8];
            end
        end
    end

    always_comb
    begin
        logic [2:0] n;
        logic [LEN_W-1:0] rem_dec;
        bundle_t b;
        b = '0;
        n = 3'd0;
        phase_next = phase_reg;
        op_next = op_reg;
        addr_next = addr_reg;
        remain_next = remain_reg;
        pleft_next = pleft_reg;
        elapsed_next = elapsed_reg;
        hcount_next = hcount_reg;
        hsel = hcount_reg;
        rem_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

        case (func)
            FUNC_REQUEST:
            begin
                if (phase_reg == PH_IDLE && op <= OP_CHIP_ERASE)
                begin
                    op_next = op;
                    addr_next = ADDRESS_BITS'(address);
                    remain_next = length;
                    hcount_next = 3'd0;
                    pleft_next = '0;
                    n = 3'd1;
                    case (op)
                        OP_READ_ID:
                        begin
                            phase_next = PH_ID_CMD;
                            b.res[0] = '{KIND_SPI, OPC_READ_ID, 8'h00, ST_OK};
                        end
                        OP_READ:
                        begin
                            phase_next = PH_OPC;
                            b.res[0] = '{KIND_SPI, OPC_READ, 8'h00, ST_OK};
                        end
                        OP_WRITE:
                        begin
                            if (length == '0)
                            begin
                                phase_next = PH_IDLE;
                                b.res[0] = '{KIND_DONE, 8'h00, 8'h00, ST_OK};
                            end
                            else
                            begin
                                // New page room from the request address.
                                pleft_next = (LEN_W'(PLEFT_W'(PAGE_BYTES)
                                    - {1'b0, address[PAGE_W-1:0]}) > length)
                                    ? PLEFT_W'(length)
                                    : PLEFT_W'(PAGE_BYTES) - {1'b0, address[PAGE_W-1:0]};
                                phase_next = PH_WREN;
                                b.res[0] = '{KIND_SPI, OPC_WREN, 8'h00, ST_OK};
                            end
                        end
                        default:
                        begin
                            phase_next = PH_WREN;
                            b.res[0] = '{KIND_SPI, OPC_WREN, 8'h00, ST_OK};
                        end
                    endcase
                end
            end
            FUNC_HOST_DATA:
            begin
                if (phase_reg == PH_DATA_WAIT)
                begin
                    n = 3'd1;
                    b.res[0] = '{KIND_SPI, data, 8'h00, ST_OK};
                    if (pleft_reg != '0) pleft_next = pleft_reg - 1'b1;
                    remain_next = rem_dec;
                    addr_next = addr_reg + 1'b1;
                    phase_next = PH_DATA_SENT;
                end
            end
            FUNC_SPI_REPLY:
            begin
                unique case (phase_reg)
                    PH_ID_CMD:
                    begin
                        hcount_next = 3'd0;
                        phase_next = PH_ID_BYTE;
                        n = 3'd1;
                        b.res[0] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                    end
                    PH_ID_BYTE:
                    begin
                        b.res[0] = '{KIND_HOST, 8'h00, data, ST_OK};
                        hcount_next = hcount_reg + 1'b1;
                        if (hcount_next < 3'd3)
                        begin
                            n = 3'd2;
                            b.res[1] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                        end
                        else
                        begin
                            n = 3'd3;
                            b.res[1] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            b.res[2] = '{KIND_DONE, 8'h00, 8'h00, ST_OK};
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RD_DATA:
                    begin
                        b.res[0] = '{KIND_HOST, 8'h00, data, ST_OK};
                        remain_next = rem_dec;
                        if (rem_dec != '0)
                        begin
                            n = 3'd2;
                            b.res[1] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                        end
                        else
                        begin
                            n = 3'd3;
                            b.res[1] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            b.res[2] = '{KIND_DONE, 8'h00, 8'h00, ST_OK};
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WREN:
                    begin
                        n = 3'd2;
                        b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                        b.res[1] = '{KIND_SPI, OPC_RDSR, 8'h00, ST_OK};
                        phase_next = PH_WEL_CMD;
                    end
                    PH_WEL_CMD:
                    begin
                        n = 3'd1;
                        b.res[0] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                        phase_next = PH_WEL_READ;
                    end
                    PH_WEL_READ:
                    begin
                        n = 3'd2;
                        b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                        if (!data[1])
                        begin
                            b.res[1] = '{KIND_DONE, 8'h00, 8'h00, ST_WEL_NOT_SET};
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            b.res[1] = '{KIND_SPI, opcode_of(op_reg), 8'h00, ST_OK};
                            phase_next = PH_OPC;
                        end
                    end
                    PH_OPC:
                    begin
                        if (op_reg == OP_CHIP_ERASE)
                        begin
                            n = 3'd2;
                            b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            b.res[1] = '{KIND_SPI, OPC_RDSR, 8'h00, ST_OK};
                            elapsed_next = '0;
                            phase_next = PH_POLL_CMD;
                        end
                        else
                        begin
                            n = 3'd1;
                            hsel = 3'd0;
                            b.res[0] = '{KIND_SPI, addr_sel, 8'h00, ST_OK};
                            hcount_next = 3'd1;
                            phase_next = PH_ADDR;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (hcount_reg < 3'(ADDR_BYTES))
                        begin
                            n = 3'd1;
                            b.res[0] = '{KIND_SPI, addr_sel, 8'h00, ST_OK};
                            hcount_next = hcount_reg + 1'b1;
                        end
                        else if (op_reg == OP_READ)
                        begin
                            if (remain_reg != '0)
                            begin
                                n = 3'd1;
                                b.res[0] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                                phase_next = PH_RD_DATA;
                            end
                            else
                            begin
                                n = 3'd2;
                                b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                                b.res[1] = '{KIND_DONE, 8'h00, 8'h00, ST_OK};
                                phase_next = PH_IDLE;
                            end
                        end
                        else if (op_reg == OP_WRITE)
                        begin
                            phase_next = PH_DATA_WAIT;
                        end
                        else
                        begin
                            n = 3'd2;
                            b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            b.res[1] = '{KIND_SPI, OPC_RDSR, 8'h00, ST_OK};
                            elapsed_next = '0;
                            phase_next = PH_POLL_CMD;
                        end
                    end
                    PH_DATA_SENT:
                    begin
                        if (pleft_reg != '0)
                        begin
                            phase_next = PH_DATA_WAIT;
                        end
                        else
                        begin
                            n = 3'd2;
                            b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            b.res[1] = '{KIND_SPI, OPC_RDSR, 8'h00, ST_OK};
                            elapsed_next = '0;
                            phase_next = PH_POLL_CMD;
                        end
                    end
                    PH_POLL_CMD:
                    begin
                        n = 3'd1;
                        b.res[0] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                        phase_next = PH_POLL_READ;
                    end
                    PH_POLL_READ:
                    begin
                        if (elapsed_reg >= 32'(limit))
                        begin
                            n = 3'd2;
                            b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            b.res[1] = '{KIND_DONE, 8'h00, 8'h00, ST_TIMEOUT};
                            phase_next = PH_IDLE;
                        end
                        else if (data[0])
                        begin
                            n = 3'd1;
                            b.res[0] = '{KIND_SPI, DUMMY_BYTE, 8'h00, ST_OK};
                        end
                        else
                        begin
                            n = 3'd2;
                            b.res[0] = '{KIND_RELEASE, 8'h00, 8'h00, ST_OK};
                            if (op_reg == OP_WRITE && remain_reg != '0)
                            begin
                                pleft_next = (LEN_W'(room) > remain_reg)
                                    ? PLEFT_W'(remain_reg) : room;
                                b.res[1] = '{KIND_SPI, OPC_WREN, 8'h00, ST_OK};
                                phase_next = PH_WREN;
                            end
                            else
                            begin
                                b.res[1] = '{KIND_DONE, 8'h00, 8'h00, ST_OK};
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        n = 3'd0;
                    end
                endcase
            end
            default:
            begin
                if (elapsed_reg != 32'hFFFF_FFFF) elapsed_next = elapsed_reg + 1'b1;
            end
        endcase
        b.count = n;
        bundle = b;
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg <= '0;
            addr_reg <= '0;
            remain_reg <= '0;
            pleft_reg <= '0;
            elapsed_reg <= '0;
            hcount_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            op_reg <= op_next;
            addr_reg <= addr_next;
            remain_reg <= remain_next;
            pleft_reg <= pleft_next;
            elapsed_reg <= elapsed_next;
            hcount_reg <= hcount_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/snfcs_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module snfcs_out_queue
    import snfcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  bundle_t bundle,
    output logic can_load,
    snfcs_out_if.source out_ch
);
    logic [2:0] count_reg;
    result_t [MAX_RESULTS-1:0] res_reg;
    logic [2:0] pos_reg;
    logic pop;
    logic final_word;
    logic busy;

    assign busy = (pos_reg != count_reg);
    assign pop = out_ch.valid && out_ch.ready;
    assign final_word = (pos_reg + 3'd1 == count_reg);
    // A new bundle may enter once the last word of the held bundle leaves.
    assign can_load = !busy || (pop && final_word);

    assign out_ch.valid = busy;
    assign out_ch.kind = res_reg[pos_reg[1:0]].kind;
    assign out_ch.spi_byte = res_reg[pos_reg[1:0]].spi_byte;
    assign out_ch.host_byte = res_reg[pos_reg[1:0]].host_byte;
    assign out_ch.status = res_reg[pos_reg[1:0]].status;
    assign out_ch.last = final_word;

    // Hold the bundle and step through its words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg <= '0;
        end
        else if (load && can_load)
        begin
            count_reg <= bundle.count;
            pos_reg <= '0;
        end
        else if (pop)
        begin
            pos_reg <= pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            res_reg <= bundle.res;
        end
    end
endmodule
`default_nettype wire

@@ rtl/spi_nor_flash_command_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// SPI NOR flash command sequencer. Each input word (host request, host write
// byte, SPI reply byte or millisecond tick) is handled by a single pass of
// logic that computes up to three result words, which sit in an output
// buffer and leave one per cycle while the output is ready. A new input
// word is taken in the cycle the last result of the previous word is taken,
// so the rate is one input word per cycle when each word yields at most one
// result and the output is ready; a word with more results holds the input
// until the buffer has passed them all on. Timeouts are written on the
// configuration channel (index 0 program, 1 sector, 2 block, 3 chip erase).
module spi_nor_flash_command_sequencer_unit
    import snfcs_pkg::*;
#(
    parameter int PAGE_BYTES = 256,
    parameter int ADDRESS_BITS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    snfcs_in_if.sink in_ch,
    snfcs_out_if.source out_ch,
    snfcs_cfg_if.sink cfg
);
    logic [TIMEOUT_W-1:0] to_program_reg;
    logic [TIMEOUT_W-1:0] to_sector_reg;
    logic [TIMEOUT_W-1:0] to_block_reg;
    logic [TIMEOUT_W-1:0] to_chip_reg;
    logic can_load;
    logic step;
    bundle_t bundle;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = can_load;
    assign step = in_ch.valid && can_load;

    // Timeout registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            to_program_reg <= TIMEOUT_W'(3);
            to_sector_reg <= TIMEOUT_W'(400);
            to_block_reg <= TIMEOUT_W'(2000);
            to_chip_reg <= TIMEOUT_W'(200000);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PROGRAM_TO: to_program_reg <= cfg.data;
                REG_SECTOR_TO: to_sector_reg <= cfg.data;
                REG_BLOCK_TO: to_block_reg <= cfg.data;
                REG_CHIP_TO: to_chip_reg <= cfg.data;
                default: to_chip_reg <= to_chip_reg;
            endcase
        end
    end

    snfcs_core #(
        .PAGE_BYTES(PAGE_BYTES),
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .func(in_ch.func),
        .op(in_ch.op),
        .address(in_ch.address),
        .length(in_ch.length),
        .data(in_ch.data),
        .limit_program(to_program_reg),
        .limit_sector(to_sector_reg),
        .limit_block(to_block_reg),
        .limit_chip(to_chip_reg),
        .bundle(bundle)
    );

    snfcs_out_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .load(step),
        .bundle(bundle),
        .can_load(can_load),
        .out_ch(out_ch)
    );
endmodule
`default_nettype wire
